[hdl/ppts_pkg.sv]
// shared types and constants for the periodic priority task scheduler
// no dependencies; imported by ppts_div and the top level
package ppts_pkg;

  localparam int MAX_TASKS_DEF = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int NRES_W        = 4;

  localparam int KIND_W    = 3;
  localparam int TID_W     = 3;
  localparam int PRIO_W    = 8;
  localparam int PER_W     = 16;
  localparam int STAT_W    = 3;
  localparam int RID_W     = 3;
  localparam int TICK_W    = 32;
  localparam int PROD_W    = TICK_W + PER_W;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  localparam logic [TICK_W-1:0] LCM_SAT = '1;

  typedef enum logic [KIND_W-1:0] {
    K_INIT   = 3'd0,
    K_DEINIT = 3'd1,
    K_RUN    = 3'd2,
    K_STOP   = 3'd3,
    K_CREATE = 3'd4,
    K_DELETE = 3'd5,
    K_MODIFY = 3'd6,
    K_TICK   = 3'd7
  } kind_t;

  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_STATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_ARGS  = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd3;
  localparam logic [STAT_W-1:0] ST_ID    = 3'd4;

  typedef enum logic [1:0] {
    MODE_UNINIT = 2'd0,
    MODE_INIT   = 2'd1,
    MODE_RUN    = 2'd2
  } mode_t;

  typedef struct packed {
    logic              start;
    logic [TICK_W-1:0] dividend;
    logic [PER_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TICK_W-1:0] quotient;
    logic [PER_W-1:0]  remainder;
  } div_rsp_t;

endpackage

[hdl/periodic_priority_task_scheduler.sv]
// periodic priority task scheduler: sequencer around the task table memory
// depends on ppts_pkg, ppts_ram and ppts_div
//
//  channel | ports             | tdata (low bit up)                 | tuser  | tlast
//  --------+-------------------+------------------------------------+--------+-------------
//  input   | in_tvalid/tready  | task_id, priority_req, period, pad | kind   | -
//  result  | out_tvalid/tready | status, result_id, pad             | due    | last result
//
// one command at a time. a command scans the table entry by entry (read, then compare),
// then moves entries for an insert or removal (read, then write) and sends its result.
// a tick takes each entry through a period test, euclid gcd steps and a quotient on the
// bit-serial divider and a multiply; only the period test once the lcm has saturated.
// reset leaves the scheduler uninitialized with an empty table and zero counter.
// the result register lets an item in while its last beat waits; a stalled result
// side holds the sequencer only at the next beat it must send.
module periodic_priority_task_scheduler #(
  parameter int MAX_TASKS = ppts_pkg::MAX_TASKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ppts_pkg::IN_DATA_W-1:0]      in_tdata,   // task_id, priority_req, period
  input  logic [ppts_pkg::KIND_W-1:0]         in_tuser,   // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ppts_pkg::OUT_DATA_W-1:0]     out_tdata,  // status, result_id
  output logic                                out_tuser,  // due
  output logic                                out_tlast
);
  import ppts_pkg::*;

  localparam int IW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW   = $clog2(MAX_TASKS + 1);
  localparam int IDCW = (IW > TID_W) ? IW : TID_W;
  localparam int EW   = IW + PRIO_W + PER_W;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_SCAN_RD, S_SCAN_CMP, S_SCAN_DONE, S_SH_RD, S_SH_WR, S_INS_WR,
    S_RESP, S_T_RD, S_T_LOAD, S_T_MOD, S_T_EMIT, S_T_LCM, S_T_GCD, S_T_QUO, S_T_MUL,
    S_T_SAT, S_T_NEXT, S_T_END
  } state_t;

  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  kind_t             kind_r, kind_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [TID_W-1:0]  tid_r, tid_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic [PER_W-1:0]  per_r, per_nxt;
  logic [STAT_W-1:0] st_r, st_nxt;
  logic [RID_W-1:0]  rid_r, rid_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     sh_i_r, sh_i_nxt;
  logic [IW-1:0]     sh_end_r, sh_end_nxt;
  logic              sh_up_r, sh_up_nxt;
  logic [IW-1:0]     dst_r, dst_nxt;
  logic [IW-1:0]     new_id_r, new_id_nxt;
  logic [MAX_TASKS-1:0] used_r, used_nxt;
  logic              found_r, found_nxt;
  logic [IW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     ple_r, ple_nxt;
  logic [CW-1:0]     pgt_r, pgt_nxt;
  logic [CW-1:0]     slt_r, slt_nxt;
  logic [IW-1:0]     ent_id_r, ent_id_nxt;
  logic [PER_W-1:0]  ent_per_r, ent_per_nxt;
  logic [TICK_W-1:0] h_r, h_nxt;
  logic [PER_W-1:0]  gb_r, gb_nxt;
  logic [TICK_W-1:0] q_r, q_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              due_r, due_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [IW-1:0]     pend_id_r, pend_id_nxt;
  logic [NRES_W-1:0] n_r, n_nxt;

  logic              out_v_r, out_v_nxt;
  logic [STAT_W-1:0] out_st_r, out_st_nxt;
  logic [RID_W-1:0]  out_id_r, out_id_nxt;
  logic              out_due_r, out_due_nxt;
  logic              out_last_r, out_last_nxt;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr, mem_raddr;
  logic [EW-1:0]     mem_wdata, mem_rdata;
  div_req_t          dreq;
  div_rsp_t          drsp;

  logic              slot_free;
  logic [CW-1:0]     cnt_m1;
  logic [IW-1:0]     last_idx;
  logic [IW-1:0]     e_id;
  logic [PRIO_W-1:0] e_pr;
  logic [PER_W-1:0]  e_per;
  logic [IW-1:0]     fid;
  logic [CW-1:0]     newpos;
  logic              emit;
  logic [STAT_W-1:0] emit_st;
  logic [RID_W-1:0]  emit_id;
  logic              emit_due;
  logic              emit_last;

  ppts_ram #(.WIDTH(EW), .DEPTH(MAX_TASKS)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ppts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign slot_free = !out_v_r || out_tready;
  assign cnt_m1    = cnt_r - CW'(1);
  assign last_idx  = cnt_m1[IW-1:0];
  assign e_id      = mem_rdata[IW-1:0];
  assign e_pr      = mem_rdata[IW +: PRIO_W];
  assign e_per     = mem_rdata[IW+PRIO_W +: PER_W];
  assign newpos    = ple_r + ((pgt_r == '0) ? slt_r : CW'(0));

  // lowest id not in use
  always_comb begin
    fid = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!used_r[i]) fid = IW'(i);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    kind_nxt    = kind_r;
    cnt_nxt     = cnt_r;
    tick_nxt    = tick_r;
    tid_nxt     = tid_r;
    prio_nxt    = prio_r;
    per_nxt     = per_r;
    st_nxt      = st_r;
    rid_nxt     = rid_r;
    idx_nxt     = idx_r;
    sh_i_nxt    = sh_i_r;
    sh_end_nxt  = sh_end_r;
    sh_up_nxt   = sh_up_r;
    dst_nxt     = dst_r;
    new_id_nxt  = new_id_r;
    used_nxt    = used_r;
    found_nxt   = found_r;
    pos_nxt     = pos_r;
    ple_nxt     = ple_r;
    pgt_nxt     = pgt_r;
    slt_nxt     = slt_r;
    ent_id_nxt  = ent_id_r;
    ent_per_nxt = ent_per_r;
    h_nxt       = h_r;
    gb_nxt      = gb_r;
    q_nxt       = q_r;
    prod_nxt    = prod_r;
    due_nxt     = due_r;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    n_nxt       = n_r;
    mem_we      = 1'b0;
    mem_waddr   = dst_r;
    mem_wdata   = {per_r, prio_r, new_id_r};
    mem_raddr   = idx_r;
    dreq.start    = 1'b0;
    dreq.dividend = tick_r;
    dreq.divisor  = ent_per_r;
    emit      = 1'b0;
    emit_st   = ST_OK;
    emit_id   = '0;
    emit_due  = 1'b0;
    emit_last = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = kind_t'(in_tuser);
          tid_nxt   = in_tdata[TID_W-1:0];
          prio_nxt  = in_tdata[TID_W +: PRIO_W];
          per_nxt   = in_tdata[TID_W+PRIO_W +: PER_W];
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        st_nxt    = ST_OK;
        rid_nxt   = '0;
        idx_nxt   = '0;
        used_nxt  = '0;
        found_nxt = 1'b0;
        ple_nxt   = '0;
        pgt_nxt   = '0;
        slt_nxt   = '0;
        state_nxt = S_RESP;
        unique case (kind_r)
          K_INIT: mode_nxt = MODE_INIT;
          K_DEINIT: begin
            cnt_nxt  = '0;
            mode_nxt = MODE_UNINIT;
          end
          K_RUN: begin
            if (mode_r != MODE_INIT) st_nxt = ST_STATE;
            else mode_nxt = MODE_RUN;
          end
          K_STOP: begin
            if (mode_r == MODE_UNINIT) st_nxt = ST_STATE;
            else mode_nxt = MODE_INIT;
          end
          K_CREATE: begin
            priority if (mode_r == MODE_UNINIT) st_nxt = ST_STATE;
            else if (per_r == '0) st_nxt = ST_ARGS;
            else if (cnt_r >= CW'(MAX_TASKS)) st_nxt = ST_FULL;
            else state_nxt = (cnt_r == '0) ? S_SCAN_DONE : S_SCAN_RD;
          end
          K_DELETE: begin
            if (mode_r == MODE_UNINIT) st_nxt = ST_STATE;
            else state_nxt = (cnt_r == '0) ? S_SCAN_DONE : S_SCAN_RD;
          end
          K_MODIFY: begin
            priority if (mode_r == MODE_UNINIT) st_nxt = ST_STATE;
            else if (per_r == '0) st_nxt = ST_ARGS;
            else state_nxt = (cnt_r == '0) ? S_SCAN_DONE : S_SCAN_RD;
          end
          K_TICK: begin
            if (mode_r != MODE_RUN) begin
              st_nxt = ST_STATE;
            end else begin
              tick_nxt = tick_r + TICK_W'(1);
              if (cnt_r != '0) begin
                h_nxt      = TICK_W'(1);
                n_nxt      = '0;
                pend_v_nxt = 1'b0;
                state_nxt  = S_T_RD;
              end
            end
          end
        endcase
      end

      S_SCAN_RD: begin
        mem_raddr = idx_r;
        state_nxt = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (kind_r == K_CREATE) begin
          used_nxt[e_id] = 1'b1;
          if (e_pr <= prio_r) ple_nxt = ple_r + CW'(1);
        end else if (!found_r) begin
          if (IDCW'(e_id) == IDCW'(tid_r)) begin
            found_nxt = 1'b1;
            pos_nxt   = idx_r;
          end else if (e_pr > prio_r) begin
            pgt_nxt = pgt_r + CW'(1);
          end else begin
            ple_nxt = ple_r + CW'(1);
          end
        end else if (e_pr < prio_r) begin
          slt_nxt = slt_r + CW'(1);
        end
        if (idx_r == last_idx) begin
          state_nxt = S_SCAN_DONE;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_SCAN_RD;
        end
      end

      S_SCAN_DONE: begin
        state_nxt = S_RESP;
        if (kind_r == K_CREATE) begin
          new_id_nxt = fid;
          rid_nxt    = RID_W'(fid);
          dst_nxt    = ple_r[IW-1:0];
          if (ple_r < cnt_r) begin
            sh_up_nxt  = 1'b1;
            sh_i_nxt   = last_idx;
            sh_end_nxt = ple_r[IW-1:0];
            state_nxt  = S_SH_RD;
          end else begin
            state_nxt = S_INS_WR;
          end
        end else if (!found_r) begin
          st_nxt = ST_ID;
        end else if (kind_r == K_DELETE) begin
          if (pos_r == last_idx) begin
            cnt_nxt = cnt_m1;
          end else begin
            sh_up_nxt  = 1'b0;
            sh_i_nxt   = pos_r + IW'(1);
            sh_end_nxt = last_idx;
            state_nxt  = S_SH_RD;
          end
        end else begin
          // modify: take the entry out and put it back at its new place
          new_id_nxt = IW'(tid_r);
          dst_nxt    = newpos[IW-1:0];
          sh_end_nxt = newpos[IW-1:0];
          priority if (newpos[IW-1:0] < pos_r) begin
            sh_up_nxt = 1'b1;
            sh_i_nxt  = pos_r - IW'(1);
            state_nxt = S_SH_RD;
          end else if (newpos[IW-1:0] > pos_r) begin
            sh_up_nxt = 1'b0;
            sh_i_nxt  = pos_r + IW'(1);
            state_nxt = S_SH_RD;
          end else begin
            state_nxt = S_INS_WR;
          end
        end
      end

      S_SH_RD: begin
        mem_raddr = sh_i_r;
        state_nxt = S_SH_WR;
      end

      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = sh_up_r ? (sh_i_r + IW'(1)) : (sh_i_r - IW'(1));
        mem_wdata = mem_rdata;
        if (sh_i_r == sh_end_r) begin
          if (kind_r == K_DELETE) begin
            cnt_nxt   = cnt_m1;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_INS_WR;
          end
        end else begin
          sh_i_nxt  = sh_up_r ? (sh_i_r - IW'(1)) : (sh_i_r + IW'(1));
          state_nxt = S_SH_RD;
        end
      end

      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = dst_r;
        mem_wdata = {per_r, prio_r, new_id_r};
        if (kind_r == K_CREATE) cnt_nxt = cnt_r + CW'(1);
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_st   = st_r;
          emit_id   = rid_r;
          state_nxt = S_IDLE;
        end
      end

      S_T_RD: begin
        mem_raddr = idx_r;
        state_nxt = S_T_LOAD;
      end

      S_T_LOAD: begin
        ent_id_nxt  = e_id;
        ent_per_nxt = e_per;
        if (e_per == '0) begin
          state_nxt = S_T_NEXT;
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = tick_r;
          dreq.divisor  = e_per;
          state_nxt     = S_T_MOD;
        end
      end

      S_T_MOD: begin
        if (drsp.done) begin
          due_nxt   = (drsp.remainder == '0) && (n_r < NRES_W'(MAX_RESULTS));
          state_nxt = S_T_EMIT;
        end
      end

      // a due id is held back one beat so the final one can carry tlast
      S_T_EMIT: begin
        if (!due_r) begin
          state_nxt = S_T_LCM;
        end else if (!pend_v_r || slot_free) begin
          if (pend_v_r) begin
            emit      = 1'b1;
            emit_id   = RID_W'(pend_id_r);
            emit_due  = 1'b1;
            emit_last = 1'b0;
          end
          pend_v_nxt  = 1'b1;
          pend_id_nxt = ent_id_r;
          n_nxt       = n_r + NRES_W'(1);
          state_nxt   = S_T_LCM;
        end
      end

      S_T_LCM: begin
        if (h_r == LCM_SAT) begin
          state_nxt = S_T_NEXT;
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = h_r;
          dreq.divisor  = ent_per_r;
          gb_nxt        = ent_per_r;
          state_nxt     = S_T_GCD;
        end
      end

      // euclid: (a, b) <- (b, a mod b) until the remainder is zero
      S_T_GCD: begin
        if (drsp.done) begin
          dreq.start = 1'b1;
          if (drsp.remainder == '0) begin
            dreq.dividend = h_r;
            dreq.divisor  = gb_r;
            state_nxt     = S_T_QUO;
          end else begin
            dreq.dividend = TICK_W'(gb_r);
            dreq.divisor  = drsp.remainder;
            gb_nxt        = drsp.remainder;
          end
        end
      end

      S_T_QUO: begin
        if (drsp.done) begin
          q_nxt     = drsp.quotient;
          state_nxt = S_T_MUL;
        end
      end

      S_T_MUL: begin
        prod_nxt  = q_r * ent_per_r;
        state_nxt = S_T_SAT;
      end

      S_T_SAT: begin
        h_nxt     = (prod_r[PROD_W-1:TICK_W] != '0) ? LCM_SAT : prod_r[TICK_W-1:0];
        state_nxt = S_T_NEXT;
      end

      S_T_NEXT: begin
        if (idx_r == last_idx) begin
          state_nxt = S_T_END;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_T_RD;
        end
      end

      S_T_END: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_id   = pend_v_r ? RID_W'(pend_id_r) : RID_W'(0);
          emit_due  = pend_v_r;
          if (tick_r == h_r) tick_nxt = '0;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_v_nxt    = out_v_r;
    out_st_nxt   = out_st_r;
    out_id_nxt   = out_id_r;
    out_due_nxt  = out_due_r;
    out_last_nxt = out_last_r;
    if (emit) begin
      out_v_nxt    = 1'b1;
      out_st_nxt   = emit_st;
      out_id_nxt   = emit_id;
      out_due_nxt  = emit_due;
      out_last_nxt = emit_last;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= MODE_UNINIT;
      cnt_r    <= '0;
      tick_r   <= '0;
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      n_r      <= '0;
      found_r  <= 1'b0;
      used_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      cnt_r    <= cnt_nxt;
      tick_r   <= tick_nxt;
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
      n_r      <= n_nxt;
      found_r  <= found_nxt;
      used_r   <= used_nxt;
    end
    kind_r     <= kind_nxt;
    tid_r      <= tid_nxt;
    prio_r     <= prio_nxt;
    per_r      <= per_nxt;
    st_r       <= st_nxt;
    rid_r      <= rid_nxt;
    idx_r      <= idx_nxt;
    sh_i_r     <= sh_i_nxt;
    sh_end_r   <= sh_end_nxt;
    sh_up_r    <= sh_up_nxt;
    dst_r      <= dst_nxt;
    new_id_r   <= new_id_nxt;
    pos_r      <= pos_nxt;
    ple_r      <= ple_nxt;
    pgt_r      <= pgt_nxt;
    slt_r      <= slt_nxt;
    ent_id_r   <= ent_id_nxt;
    ent_per_r  <= ent_per_nxt;
    h_r        <= h_nxt;
    gb_r       <= gb_nxt;
    q_r        <= q_nxt;
    prod_r     <= prod_nxt;
    due_r      <= due_nxt;
    pend_id_r  <= pend_id_nxt;
    out_st_r   <= out_st_nxt;
    out_id_r   <= out_id_nxt;
    out_due_r  <= out_due_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_DATA_W - STAT_W - RID_W){1'b0}}, out_id_r, out_st_r};
  assign out_tuser  = out_due_r;
  assign out_tlast  = out_last_r;

endmodule

[hdl/ppts_ram.sv]
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module ppts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/ppts_div.sv]
// iterative restoring divider, 32-bit dividend by 16-bit divisor, one bit a cycle
// depends on ppts_pkg for widths and the request/response structs
module ppts_div (
  input  logic                clk,
  input  logic                rst_n,
  input  ppts_pkg::div_req_t  req,
  output ppts_pkg::div_rsp_t  rsp
);
  import ppts_pkg::*;

  localparam int CNT_W = $clog2(TICK_W + 1);

  logic [TICK_W-1:0] dvd_r;
  logic [PER_W-1:0]  rem_r;
  logic [PER_W-1:0]  dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [PER_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, dvd_r[TICK_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        dvd_r  <= req.dividend;
        dvs_r  <= req.divisor;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(TICK_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? PER_W'(trial - {1'b0, dvs_r}) : trial[PER_W-1:0];
        dvd_r <= {dvd_r[TICK_W-2:0], fits};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dvd_r;
  assign rsp.remainder = rem_r;

endmodule
